// ===== rtl/cst_pkg.sv =====
package cst_pkg;

    localparam int MAX_TOKENS = 10;
    localparam int MAX_CHARS  = 128;

    // token count and kept-character count limits at their register widths
    localparam logic [3:0] TOKEN_LIMIT = 4'(MAX_TOKENS);
    localparam logic [6:0] KEEP_LIMIT  = 7'(MAX_CHARS - 1);

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STR,
        MODE_ZERO,
        MODE_DEC,
        MODE_HEX
    } t_scan_mode;

    typedef enum logic [1:0] {
        KIND_WORD,
        KIND_STR,
        KIND_INT
    } t_token_kind;

    typedef struct packed {
        t_scan_mode  mode;
        logic [31:0] acc;
        logic [6:0]  chars;
        logic [3:0]  tokens;
        logic        err;
    } t_scan_state;

    typedef struct packed {
        logic        token_done;
        t_token_kind done_kind;
        logic [31:0] done_value;
        logic [6:0]  done_length;
        logic [3:0]  done_index;
        logic        char_valid;
        logic [7:0]  char_value;
        logic [6:0]  char_pos;
        logic        finished;
        logic [3:0]  token_total;
        logic        overflow_error;
    } t_scan_result;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDERSCORE;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            r = {1'b1, 4'(b - CH_ZERO)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/cst_step.sv =====
module cst_step (
    input  logic [7:0]           i_char,
    input  cst_pkg::t_scan_state i_state,
    output cst_pkg::t_scan_state o_state,
    output cst_pkg::t_scan_result o_result
);

    logic                 fin;
    cst_pkg::t_token_kind fin_kind;
    logic                 again;
    logic                 store;
    logic [4:0]           hv;
    logic [3:0]           digit;
    cst_pkg::t_scan_state s;
    cst_pkg::t_scan_result r;

    assign hv    = cst_pkg::hex_digit(i_char);
    assign digit = 4'(i_char - cst_pkg::CH_ZERO);

    always_comb begin
        s        = i_state;
        r        = '0;
        fin      = 1'b0;
        fin_kind = cst_pkg::KIND_WORD;
        again    = 1'b0;
        store    = 1'b0;

        if (i_char == cst_pkg::CH_NUL) begin
            fin = (s.mode != cst_pkg::MODE_IDLE);
            case (s.mode)
                cst_pkg::MODE_WORD: fin_kind = cst_pkg::KIND_WORD;
                cst_pkg::MODE_STR:  fin_kind = cst_pkg::KIND_STR;
                default:            fin_kind = cst_pkg::KIND_INT;
            endcase
        end else begin
            case (s.mode)
                cst_pkg::MODE_WORD: begin
                    if (cst_pkg::is_alpha(i_char)) begin
                        store = 1'b1;
                    end else begin
                        fin   = 1'b1;
                        again = 1'b1;
                    end
                end
                cst_pkg::MODE_STR: begin
                    if (i_char == cst_pkg::CH_QUOTE) begin
                        fin      = 1'b1;
                        fin_kind = cst_pkg::KIND_STR;
                    end else begin
                        store = 1'b1;
                    end
                end
                cst_pkg::MODE_ZERO: begin
                    if (i_char == cst_pkg::CH_LOWER_X) begin
                        s.mode = cst_pkg::MODE_HEX;
                    end else if (cst_pkg::is_digit(i_char)) begin
                        s.mode = cst_pkg::MODE_DEC;
                        s.acc  = {28'd0, digit};
                    end else begin
                        fin      = 1'b1;
                        fin_kind = cst_pkg::KIND_INT;
                        again    = 1'b1;
                    end
                end
                cst_pkg::MODE_DEC: begin
                    if (cst_pkg::is_digit(i_char)) begin
                        s.acc = {s.acc[28:0], 3'd0} + {s.acc[30:0], 1'b0} + {28'd0, digit};
                    end else begin
                        fin      = 1'b1;
                        fin_kind = cst_pkg::KIND_INT;
                        again    = 1'b1;
                    end
                end
                cst_pkg::MODE_HEX: begin
                    if (hv[4]) begin
                        s.acc = {s.acc[27:0], hv[3:0]};
                    end else begin
                        fin      = 1'b1;
                        fin_kind = cst_pkg::KIND_INT;
                        again    = 1'b1;
                    end
                end
                default: begin
                    s.mode = cst_pkg::MODE_IDLE;
                    again  = 1'b1;
                end
            endcase
        end

        // complete the pending token; drop it once all slots are used
        if (fin) begin
            if (s.tokens < cst_pkg::TOKEN_LIMIT) begin
                r.token_done  = 1'b1;
                r.done_kind   = fin_kind;
                r.done_value  = (fin_kind == cst_pkg::KIND_INT) ? s.acc : 32'd0;
                r.done_length = (fin_kind == cst_pkg::KIND_INT) ? 7'd0 : s.chars;
                r.done_index  = s.tokens;
                s.tokens      = s.tokens + 4'd1;
            end else begin
                s.err = 1'b1;
            end
            s.mode = cst_pkg::MODE_IDLE;
        end

        // re-examine the byte that ended the token as a possible start
        if (again) begin
            if (cst_pkg::is_alpha(i_char)) begin
                s.mode  = cst_pkg::MODE_WORD;
                s.chars = 7'd0;
                store   = 1'b1;
            end else if (i_char == cst_pkg::CH_ZERO) begin
                s.mode = cst_pkg::MODE_ZERO;
                s.acc  = 32'd0;
            end else if (cst_pkg::is_digit(i_char)) begin
                s.mode = cst_pkg::MODE_DEC;
                s.acc  = {28'd0, digit};
            end else if (i_char == cst_pkg::CH_QUOTE) begin
                s.mode  = cst_pkg::MODE_STR;
                s.chars = 7'd0;
            end
        end

        if (store && s.tokens < cst_pkg::TOKEN_LIMIT && s.chars < cst_pkg::KEEP_LIMIT) begin
            r.char_valid = 1'b1;
            r.char_value = i_char;
            r.char_pos   = s.chars;
            s.chars      = s.chars + 7'd1;
        end

        r.token_total    = s.tokens;
        r.overflow_error = s.err;

        // terminator: report final counts, then clear for the next command
        if (i_char == cst_pkg::CH_NUL) begin
            r.finished = 1'b1;
            s          = '0;
            s.mode     = cst_pkg::MODE_IDLE;
        end
    end

    assign o_state  = s;
    assign o_result = r;

endmodule

// ===== rtl/command_string_tokenizer_unit.sv =====
// Command string tokenizer: takes one byte per beat and returns exactly one result beat
// per input beat, in the cycle after acceptance, at a sustained rate of one byte per cycle
// when not stalled; the scan state update and the result are computed combinationally
// between the scan state registers and the output register. A zero byte ends the command
// and clears all state. Words, single-quoted strings, decimal and 0x hex integers (modulo
// 2^32) are reported when complete; stored characters are reported as they arrive. Up to
// ten tokens are reported per command, later ones set a sticky overflow flag until the
// terminator. The input is ready whenever the output register is empty or being drained.
module command_string_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_token_done,
    output logic [1:0]  o_done_kind,
    output logic [31:0] o_done_value,
    output logic [6:0]  o_done_length,
    output logic [3:0]  o_done_index,
    output logic        o_char_valid,
    output logic [7:0]  o_char_value,
    output logic [6:0]  o_char_pos,
    output logic        o_finished,
    output logic [3:0]  o_token_total,
    output logic        o_overflow_error
);

    cst_pkg::t_scan_state  r_state;
    cst_pkg::t_scan_state  n_state;
    cst_pkg::t_scan_result r_result;
    cst_pkg::t_scan_result n_result;
    logic                  r_out_valid;
    logic                  accept;

    cst_step u_step (
        .i_char   (i_char_code),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_token_done     = r_result.token_done;
    assign o_done_kind      = r_result.done_kind;
    assign o_done_value     = r_result.done_value;
    assign o_done_length    = r_result.done_length;
    assign o_done_index     = r_result.done_index;
    assign o_char_valid     = r_result.char_valid;
    assign o_char_value     = r_result.char_value;
    assign o_char_pos       = r_result.char_pos;
    assign o_finished       = r_result.finished;
    assign o_token_total    = r_result.token_total;
    assign o_overflow_error = r_result.overflow_error;

endmodule
